@@ src/mab_pkg.sv @@
// ----------------------------------------------------------------------------
// mab_pkg
// Shared types and constants for the masked add/subtract blend pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package mab_pkg;

    localparam int ChanW    = 8;
    localparam int PixelW   = 3 * ChanW;
    localparam int PercentW = 8;
    localparam int MagW     = 7;
    localparam int ScaleW   = 9;     // q = 0..256
    localparam int SumW     = 17;    // t*m + d*(255-m), plus rounding headroom

    localparam logic [MagW-1:0] PercentMax = 7'd100;
    localparam logic [ChanW-1:0] ChanMax   = 8'hff;

    // q = trunc(mag * 256 / 100) == (mag * 10486) >> 12 for mag in 0..100
    localparam logic [13:0] ScaleRecip = 14'd10486;
    localparam int          ScaleShift = 12;

    typedef struct packed {
        logic              active;   // percent non-zero
        logic              sub;      // negative percent
        logic [ScaleW-1:0] q;
    } cfg_t;

    typedef struct packed {
        logic en_a;
        logic en_b;
        logic en_c;
    } stage_en_t;

endpackage : mab_pkg

`default_nettype wire

@@ src/mab_cfg.sv @@
// ----------------------------------------------------------------------------
// mab_cfg
// Strength register: saturates the signed percent and precomputes the scale.
// ----------------------------------------------------------------------------
`default_nettype none

module mab_cfg
    import mab_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [PercentW-1:0] cfg_wr_data,
    output cfg_t                     cfg
);

    cfg_t                cfg_reg;
    cfg_t                cfg_next;
    logic signed [PercentW-1:0] pct;
    logic [MagW-1:0]     mag;
    logic [20:0]         scaled;

    always_comb
    begin
        pct = $signed(cfg_wr_data);
        if (pct < -8'sd100)
        begin
            mag = PercentMax;
        end
        else if (pct > 8'sd100)
        begin
            mag = PercentMax;
        end
        else if (pct < 8'sd0)
        begin
            mag = MagW'(-pct);
        end
        else
        begin
            mag = MagW'(pct);
        end
        scaled          = 21'(mag) * 21'(ScaleRecip);
        cfg_next.active = (pct != 8'sd0);
        cfg_next.sub    = pct[PercentW-1];
        cfg_next.q      = scaled[ScaleShift +: ScaleW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule : mab_cfg

`default_nettype wire

@@ src/mab_lane.sv @@
// ----------------------------------------------------------------------------
// mab_lane
// One color channel: scale, add/sub with clamp, mask mix, divide by 255.
// ----------------------------------------------------------------------------
`default_nettype none

module mab_lane
    import mab_pkg::*;
(
    input  wire logic             clk,
    input  wire cfg_t             cfg,
    input  wire stage_en_t        en,
    input  wire logic [ChanW-1:0] src,
    input  wire logic [ChanW-1:0] dst,
    input  wire logic [ChanW-1:0] mask,
    input  wire logic             pass,
    output logic      [ChanW-1:0] result
);

    // stage A
    logic [ChanW-1:0]  add_a_reg;
    logic [ChanW-1:0]  dst_a_reg;
    logic [ChanW-1:0]  mask_a_reg;
    logic              pass_a_reg;
    logic [16:0]       prod_a_next;

    // stage B
    logic [SumW-1:0]   mix_b_reg;
    logic [SumW-1:0]   mix_b_next;
    logic [ChanW-1:0]  dst_b_reg;
    logic              pass_b_reg;
    logic [ChanW:0]    sum_b;
    logic [ChanW-1:0]  t_b;
    logic [15:0]       fg_b;
    logic [15:0]       bg_b;

    // stage C
    logic [ChanW-1:0]  res_c_reg;
    logic [ChanW-1:0]  res_c_next;
    logic [SumW-1:0]   div_c;

    assign prod_a_next = 17'(src) * 17'(cfg.q);

    always_ff @(posedge clk)
    begin
        if (en.en_a)
        begin
            add_a_reg  <= prod_a_next[15:8];
            dst_a_reg  <= dst;
            mask_a_reg <= mask;
            pass_a_reg <= pass;
        end
    end

    always_comb
    begin
        if (cfg.sub)
        begin
            sum_b = {1'b0, dst_a_reg} - {1'b0, add_a_reg};
            t_b   = sum_b[ChanW] ? '0 : sum_b[ChanW-1:0];
        end
        else
        begin
            sum_b = {1'b0, dst_a_reg} + {1'b0, add_a_reg};
            t_b   = sum_b[ChanW] ? ChanMax : sum_b[ChanW-1:0];
        end
        fg_b       = 16'(t_b) * 16'(mask_a_reg);
        bg_b       = 16'(dst_a_reg) * 16'(ChanMax - mask_a_reg);
        mix_b_next = SumW'(fg_b) + SumW'(bg_b);
    end

    always_ff @(posedge clk)
    begin
        if (en.en_b)
        begin
            mix_b_reg  <= mix_b_next;
            dst_b_reg  <= dst_a_reg;
            pass_b_reg <= pass_a_reg;
        end
    end

    // x / 255 == (x + (x >> 8) + 1) >> 8 for x in 0..65025, the mix range
    always_comb
    begin
        div_c      = mix_b_reg + (mix_b_reg >> 8) + SumW'(1);
        res_c_next = pass_b_reg ? dst_b_reg : div_c[8 +: ChanW];
    end

    always_ff @(posedge clk)
    begin
        if (en.en_c)
        begin
            res_c_reg <= res_c_next;
        end
    end

    assign result = res_c_reg;

endmodule : mab_lane

`default_nettype wire

@@ src/masked_add_sub_blend.sv @@
// ----------------------------------------------------------------------------
// masked_add_sub_blend
// Masked additive/subtractive RGB888 blend, three-stage pipeline.
// An accepted request passes registered stages A (scale), B (mix multiply)
// and C (divide by 255); throughput 1 pixel per cycle while out_stall is low.
// A bubble in any stage is filled even while the output is stalled.
// Reset clears the stage valid bits and sets the strength to 0 (no writes).
// ----------------------------------------------------------------------------
`default_nettype none

module masked_add_sub_blend
    import mab_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [PercentW-1:0] cfg_wr_data,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [PixelW-1:0]   source_pixel,
    input  wire logic [PixelW-1:0]   dest_pixel,
    input  wire logic [ChanW-1:0]    mask_level,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic      [PixelW-1:0]   result_pixel,
    output logic                     write_enable
);

    cfg_t      cfg;
    stage_en_t en;
    logic      pass_in;
    logic      rdy_a;
    logic      rdy_b;
    logic      rdy_c;
    logic      vld_a_reg;
    logic      vld_b_reg;
    logic      vld_c_reg;
    logic      pass_a_reg;
    logic      pass_b_reg;
    logic      we_c_reg;

    mab_cfg u_cfg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // each stage moves when it is empty or the next one moves
    assign rdy_c    = !vld_c_reg || !out_stall;
    assign rdy_b    = !vld_b_reg || rdy_c;
    assign rdy_a    = !vld_a_reg || rdy_b;
    assign en.en_a  = rdy_a;
    assign en.en_b  = rdy_b;
    assign en.en_c  = rdy_c;
    assign in_stall = !rdy_a;
    assign pass_in  = (mask_level == '0) || !cfg.active;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
            begin
                vld_a_reg <= in_valid;
            end
            if (rdy_b)
            begin
                vld_b_reg <= vld_a_reg;
            end
            if (rdy_c)
            begin
                vld_c_reg <= vld_b_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a)
        begin
            pass_a_reg <= pass_in;
        end
        if (rdy_b)
        begin
            pass_b_reg <= pass_a_reg;
        end
        if (rdy_c)
        begin
            we_c_reg <= !pass_b_reg;
        end
    end

    for (genvar ch = 0; ch < 3; ch++)
    begin : g_lane
        mab_lane u_lane
        (
            .clk    (clk),
            .cfg    (cfg),
            .en     (en),
            .src    (source_pixel[ch*ChanW +: ChanW]),
            .dst    (dest_pixel[ch*ChanW +: ChanW]),
            .mask   (mask_level),
            .pass   (pass_in),
            .result (result_pixel[ch*ChanW +: ChanW])
        );
    end

    assign out_valid    = vld_c_reg;
    assign write_enable = we_c_reg;

endmodule : masked_add_sub_blend

`default_nettype wire

@@ src/mab_checker.sv @@
// ----------------------------------------------------------------------------
// mab_checker
// Port-level checks on the blend pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mab_checker
    import mab_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire logic [PixelW-1:0] dest_pixel,
    input wire logic [ChanW-1:0]  mask_level,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic [PixelW-1:0] result_pixel,
    input wire logic              write_enable
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_pixel)
                                   && $stable(write_enable))
        else $error("stalled result changed");

    // backpressure only when the output itself is full and stalled
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output free");

    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled with output draining");

    // an unstalled zero-mask request comes out unwritten, dest unchanged
    a_mask_zero: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (mask_level == '0) ##1 !out_stall ##1 !out_stall
        |=> out_valid && !write_enable && (result_pixel == $past(dest_pixel, 3)))
        else $error("zero-mask request not passed through");

endmodule : mab_checker

bind masked_add_sub_blend mab_checker u_mab_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .dest_pixel   (dest_pixel),
    .mask_level   (mask_level),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_pixel (result_pixel),
    .write_enable (write_enable)
);

`default_nettype wire
